// ----- hw/rtl/bbma_pkg.sv -----
// Package with the frame constants, the queue entry type and the CRC and scrambler functions.
`timescale 1ns / 1ps

package bbma_pkg;

   localparam logic [7:0]  PKT_LAST      = 8'd187;
   localparam logic [7:0]  PKT_LEN       = 8'd188;
   localparam logic [11:0] DF_BYTES_Q    = 12'd374;
   localparam logic [11:0] DF_BYTES_TQ   = 12'd1454;
   localparam logic [15:0] DFL_QUARTER   = 16'd2992;
   localparam logic [15:0] DFL_THREEQ    = 16'd11632;
   localparam logic [15:0] UPL_BITS      = 16'd1504;
   localparam logic [7:0]  SYNC_VAL      = 8'h47;
   localparam logic [7:0]  MATYPE_BASE   = 8'hF0;
   localparam logic [7:0]  CRC_POLY      = 8'hD5;
   localparam logic [14:0] SCR_SEED      = 15'h00A9;
   localparam logic [3:0]  HDR_LEN       = 4'd10;

   typedef enum logic [0:0] {
      CSR_RATE_SELECT = 1'b0,
      CSR_ROLLOFF     = 1'b1
   } csr_index_type;

   // Header field positions within the BBHEADER.
   typedef enum logic [3:0] {
      HB_MATYPE1 = 4'd0,
      HB_MATYPE2 = 4'd1,
      HB_UPL_HI  = 4'd2,
      HB_UPL_LO  = 4'd3,
      HB_DFL_HI  = 4'd4,
      HB_DFL_LO  = 4'd5,
      HB_SYNC    = 4'd6,
      HB_SYNCD_HI = 4'd7,
      HB_SYNCD_LO = 4'd8,
      HB_CRC     = 4'd9
   } hdr_byte_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        hdr;
      logic        rate;
      logic [1:0]  rolloff;
      logic [10:0] syncd;
      logic        last;
   } bbma_entry_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

   // Eight steps of the 1+x^14+x^15 sequence: next state in the upper bits, mask below.
   function automatic logic [22:0] scr_step(input logic [14:0] lfsr);
      logic [14:0] s;
      logic [7:0]  m;
      logic        fb;
      s = lfsr;
      m = 8'd0;
      for (int k = 0; k < 8; k++) begin
         fb = s[13] ^ s[14];
         s  = {s[13:0], fb};
         m  = {m[6:0], fb};
      end
      return {s, m};
   endfunction

endpackage

// ----- hw/rtl/bbma_front.sv -----
// Front end: packet counting, sync byte replacement by CRC-8 and frame boundary marking.
`timescale 1ns / 1ps

module bbma_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_data_byte,
   input  logic                    rate_select,
   input  logic [1:0]              rolloff,
   input  logic                    queue_full,
   output logic                    push,
   output bbma_pkg::bbma_entry_type push_entry
);
   import bbma_pkg::*;

   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  pcrc_ff, pcrc_in;
   logic [7:0]  prev_crc_ff, prev_crc_in;
   logic [10:0] fcount_ff, fcount_in;
   logic [7:0]  crc_new;
   logic [7:0]  to_boundary;
   logic [11:0] df_bytes;
   logic [11:0] count_next;
   logic        last;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   assign crc_new     = crc8_byte(pcrc_ff, req_data_byte);
   assign df_bytes    = rate_select ? DF_BYTES_TQ : DF_BYTES_Q;
   assign count_next  = {1'b0, fcount_ff} + 12'd1;
   assign last        = (count_next >= df_bytes);
   assign to_boundary = PKT_LEN - pos_ff;

   always_comb begin
      push_entry.data    = (pos_ff == 8'd0) ? prev_crc_ff : req_data_byte;
      push_entry.hdr     = (fcount_ff == 11'd0);
      push_entry.rate    = rate_select;
      push_entry.rolloff = rolloff;
      push_entry.syncd   = (pos_ff == 8'd0) ? 11'd0 : {to_boundary, 3'b000};
      push_entry.last    = last;
   end

   always_comb begin
      pos_in      = pos_ff;
      pcrc_in     = pcrc_ff;
      prev_crc_in = prev_crc_ff;
      fcount_in   = fcount_ff;
      if (push) begin
         pos_in    = (pos_ff >= PKT_LAST) ? 8'd0 : pos_ff + 8'd1;
         fcount_in = last ? 11'd0 : count_next[10:0];
         if (pos_ff == 8'd0) begin
            pcrc_in = 8'd0;
         end else begin
            pcrc_in = crc_new;
            // The payload CRC is complete on the last byte of the packet.
            if (pos_ff == PKT_LAST) begin
               prev_crc_in = crc_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= 8'd0;
         pcrc_ff     <= 8'd0;
         prev_crc_ff <= 8'd0;
         fcount_ff   <= 11'd0;
      end else begin
         pos_ff      <= pos_in;
         pcrc_ff     <= pcrc_in;
         prev_crc_ff <= prev_crc_in;
         fcount_ff   <= fcount_in;
      end
   end

endmodule

// ----- hw/rtl/bbma_queue.sv -----
// Short queue of classified bytes between the front and back ends.
`timescale 1ns / 1ps

module bbma_queue #(
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  bbma_pkg::bbma_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output logic                     empty,
   output bbma_pkg::bbma_entry_type head
);
   import bbma_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   bbma_entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hw/rtl/bbma_back.sv -----
// Back end: header insertion, header CRC, scrambling and the registered output stage.
`timescale 1ns / 1ps

module bbma_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     empty,
   input  bbma_pkg::bbma_entry_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_frame_byte,
   output logic                     rsp_frame_start,
   output logic                     rsp_frame_end,
   output logic                     rsp_run_last
);
   import bbma_pkg::*;

   logic [3:0]  idx_ff, idx_in;
   logic [7:0]  hcrc_ff, hcrc_in;
   logic [14:0] lfsr_ff, lfsr_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        start_ff, start_in;
   logic        end_ff, end_in;
   logic        runl_ff, runl_in;

   logic        out_load;
   logic        active;
   logic        in_header;
   logic [7:0]  hbyte;
   logic [7:0]  plain;
   logic [15:0] dfl;
   logic [14:0] lfsr_cur;
   logic [22:0] scr;

   assign out_load  = !valid_ff || !rsp_stall;
   assign active    = !empty && out_load;
   assign in_header = head.hdr && (idx_ff != HDR_LEN);
   assign pop       = active && !in_header;
   assign dfl       = head.rate ? DFL_THREEQ : DFL_QUARTER;

   always_comb begin
      case (hdr_byte_type'(idx_ff))
         HB_MATYPE1:  hbyte = MATYPE_BASE | {6'd0, head.rolloff};
         HB_MATYPE2:  hbyte = 8'd0;
         HB_UPL_HI:   hbyte = UPL_BITS[15:8];
         HB_UPL_LO:   hbyte = UPL_BITS[7:0];
         HB_DFL_HI:   hbyte = dfl[15:8];
         HB_DFL_LO:   hbyte = dfl[7:0];
         HB_SYNC:     hbyte = SYNC_VAL;
         HB_SYNCD_HI: hbyte = {5'd0, head.syncd[10:8]};
         HB_SYNCD_LO: hbyte = head.syncd[7:0];
         HB_CRC:      hbyte = hcrc_ff;
         default:     hbyte = 8'd0;
      endcase
   end

   // The scrambler restarts from its seed on the first header byte of every frame.
   assign plain    = in_header ? hbyte : head.data;
   assign lfsr_cur = (in_header && idx_ff == 4'd0) ? SCR_SEED : lfsr_ff;
   assign scr      = scr_step(lfsr_cur);

   always_comb begin
      idx_in   = idx_ff;
      hcrc_in  = hcrc_ff;
      lfsr_in  = lfsr_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      start_in = start_ff;
      end_in   = end_ff;
      runl_in  = runl_ff;
      if (out_load) begin
         valid_in = active;
      end
      if (active) begin
         lfsr_in  = scr[22:8];
         byte_in  = plain ^ scr[7:0];
         start_in = in_header && (idx_ff == 4'd0);
         end_in   = !in_header && head.last;
         runl_in  = !in_header;
         if (in_header) begin
            idx_in  = idx_ff + 4'd1;
            hcrc_in = crc8_byte((idx_ff == 4'd0) ? 8'd0 : hcrc_ff, hbyte);
         end else begin
            idx_in = 4'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 4'd0;
         lfsr_ff  <= SCR_SEED;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         lfsr_ff  <= lfsr_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hcrc_ff  <= hcrc_in;
      byte_ff  <= byte_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      runl_ff  <= runl_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_frame_byte  = byte_ff;
   assign rsp_frame_start = start_ff;
   assign rsp_frame_end   = end_ff;
   assign rsp_run_last    = runl_ff;

endmodule

// ----- hw/rtl/bbframe_mode_adaptation_core.sv -----
// Top level of the BBFRAME mode adaptation block: configuration registers and the three parts.
`timescale 1ns / 1ps

// Transport stream bytes enter at up to one per cycle and leave as scrambled BBFRAME bytes at
// one per cycle while rsp_stall is low. Each byte gives one data field byte; the first byte
// of every frame also brings the 10-byte BBHEADER in front of it. The output port, which
// sends one byte per cycle unless rsp_stall holds it, sets the rate: while a header goes
// out, the input keeps flowing into a queue of QUEUE_DEPTH entries and is stalled only once
// that fills. Results come out of a register, loaded when empty or when its result is taken.
module bbframe_mode_adaptation_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_frame_byte,
   output logic       rsp_frame_start,
   output logic       rsp_frame_end,
   output logic       rsp_run_last,
   input  logic       csr_write_enable,
   input  logic [0:0] csr_index,
   input  logic [1:0] csr_write_data
);
   import bbma_pkg::*;

   logic           rate_ff, rate_in;
   logic [1:0]     rolloff_ff, rolloff_in;
   logic           queue_full;
   logic           queue_empty;
   logic           push;
   logic           pop;
   bbma_entry_type push_entry;
   bbma_entry_type head;

   always_comb begin
      rate_in    = rate_ff;
      rolloff_in = rolloff_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_RATE_SELECT: rate_in    = csr_write_data[0];
            CSR_ROLLOFF:     rolloff_in = csr_write_data;
            default:         rate_in    = rate_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff    <= 1'b1;
         rolloff_ff <= 2'd0;
      end else begin
         rate_ff    <= rate_in;
         rolloff_ff <= rolloff_in;
      end
   end

   bbma_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .rate_select   (rate_ff),
      .rolloff       (rolloff_ff),
      .queue_full    (queue_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   bbma_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head       (head)
   );

   bbma_back u_back (
      .clock           (clock),
      .reset           (reset),
      .empty           (queue_empty),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_frame_start (rsp_frame_start),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_run_last    (rsp_run_last)
   );

endmodule
